[rtl/core/tone_pattern_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// Tone pattern sequencer assertion macros
// Shared assertion forms for the checker, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef TONE_PATTERN_SEQUENCER_CORE_ASSERT_SVH
`define TONE_PATTERN_SEQUENCER_CORE_ASSERT_SVH

// Check a property outside reset
`define TPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define TPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tps_pkg.sv]
// ----------------------------------------------------------------------------
// Tone pattern sequencer package
// Item types, register indexes, pattern codes and the step lookup table.
// ----------------------------------------------------------------------------
package tps_pkg;

  // Item kinds
  localparam logic [1:0] KIND_PLAY = 2'd0;
  localparam logic [1:0] KIND_STOP = 2'd1;
  localparam logic [1:0] KIND_TICK = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ONE_SHOT_FREQS     = 2'd0;
  localparam logic [1:0] CFG_ALERT_FREQS        = 2'd1;
  localparam logic [1:0] CFG_ONE_SHOT_DURATIONS = 2'd2;

  localparam int CFG_DATA_W  = 64;
  localparam int ALERT_W     = 48;

  // Pattern codes
  localparam logic [2:0] PAT_SILENT  = 3'd0;
  localparam logic [2:0] PAT_CLICK   = 3'd1;
  localparam logic [2:0] PAT_NAV     = 3'd2;
  localparam logic [2:0] PAT_CONFIRM = 3'd3;
  localparam logic [2:0] PAT_WARNING = 3'd4;
  localparam logic [2:0] PAT_ERROR   = 3'd5;
  localparam logic [2:0] PAT_ALARM   = 3'd6;
  localparam logic [2:0] PAT_STARTUP = 3'd7;

  // Fixed tones and durations
  localparam logic [15:0] DUR_WARN_ON   = 16'd200;
  localparam logic [15:0] DUR_WARN_OFF  = 16'd300;
  localparam logic [15:0] DUR_ALARM_ON  = 16'd150;
  localparam logic [15:0] DUR_ALARM_OFF = 16'd100;
  localparam logic [15:0] FREQ_START_LO  = 16'd1000;
  localparam logic [15:0] FREQ_START_MID = 16'd1500;
  localparam logic [15:0] FREQ_START_HI  = 16'd2000;
  localparam logic [15:0] DUR_START_NOTE = 16'd100;
  localparam logic [15:0] DUR_START_GAP  = 16'd50;
  localparam logic [15:0] DUR_START_LAST = 16'd150;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  action;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        tone_write;
    logic [15:0] tone_freq;
    logic        playing;
  } out_item_t;

  typedef struct packed {
    logic [63:0]        one_shot_freqs;
    logic [ALERT_W-1:0] alert_freqs;
    logic [63:0]        one_shot_durations;
  } cfg_t;

  // Number of steps in each pattern
  function automatic logic [2:0] pat_steps(logic [2:0] pat);
    logic [2:0] n;
    unique case (pat)
      PAT_SILENT:  n = 3'd0;
      PAT_CLICK:   n = 3'd1;
      PAT_NAV:     n = 3'd1;
      PAT_CONFIRM: n = 3'd2;
      PAT_WARNING: n = 3'd2;
      PAT_ERROR:   n = 3'd1;
      PAT_ALARM:   n = 3'd2;
      PAT_STARTUP: n = 3'd5;
      default:     n = 3'd0;
    endcase
    return n;
  endfunction

  // Frequency of one step
  function automatic logic [15:0] step_freq(cfg_t c, logic [2:0] pat, logic [2:0] s);
    logic [15:0] f;
    f = '0;
    unique case (pat)
      PAT_CLICK:   f = c.one_shot_freqs[15:0];
      PAT_NAV:     f = c.one_shot_freqs[31:16];
      PAT_CONFIRM: f = (s == 3'd0) ? c.one_shot_freqs[47:32] : c.one_shot_freqs[63:48];
      PAT_WARNING: f = (s == 3'd0) ? c.alert_freqs[31:16] : 16'd0;
      PAT_ERROR:   f = c.alert_freqs[15:0];
      PAT_ALARM:   f = (s == 3'd0) ? c.alert_freqs[47:32] : 16'd0;
      PAT_STARTUP: begin
        unique case (s)
          3'd0:    f = FREQ_START_LO;
          3'd2:    f = FREQ_START_MID;
          3'd4:    f = FREQ_START_HI;
          default: f = 16'd0;
        endcase
      end
      default:     f = 16'd0;
    endcase
    return f;
  endfunction

  // Duration of one step in ms
  function automatic logic [15:0] step_ms(cfg_t c, logic [2:0] pat, logic [2:0] s);
    logic [15:0] d;
    d = '0;
    unique case (pat)
      PAT_CLICK:   d = c.one_shot_durations[15:0];
      PAT_NAV:     d = c.one_shot_durations[31:16];
      PAT_CONFIRM: d = c.one_shot_durations[47:32];
      PAT_WARNING: d = (s == 3'd0) ? DUR_WARN_ON : DUR_WARN_OFF;
      PAT_ERROR:   d = c.one_shot_durations[63:48];
      PAT_ALARM:   d = (s == 3'd0) ? DUR_ALARM_ON : DUR_ALARM_OFF;
      PAT_STARTUP: begin
        unique case (s)
          3'd0, 3'd2: d = DUR_START_NOTE;
          3'd1, 3'd3: d = DUR_START_GAP;
          3'd4:       d = DUR_START_LAST;
          default:    d = 16'd0;
        endcase
      end
      default:     d = 16'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/core/tps_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Tone pattern sequencer configuration registers
// Holds the packed frequency and duration words written through the cfg port.
// ----------------------------------------------------------------------------
module tps_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output tps_pkg::cfg_t                     cfg
);
  import tps_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ONE_SHOT_FREQS:     cfg_nxt.one_shot_freqs = cfg_wdata;
        CFG_ALERT_FREQS:        cfg_nxt.alert_freqs = cfg_wdata[ALERT_W-1:0];
        CFG_ONE_SHOT_DURATIONS: cfg_nxt.one_shot_durations = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/tps_engine.sv]
// ----------------------------------------------------------------------------
// Tone pattern sequencer engine
// Holds the pattern state and works out one result per item combinationally.
// ----------------------------------------------------------------------------
module tps_engine #(
  parameter int TIME_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tps_pkg::cfg_t      cfg,
  input  logic               item_valid,
  input  tps_pkg::in_item_t  item,
  output tps_pkg::out_item_t result
);
  import tps_pkg::*;

  logic                 active_r, active_nxt;
  logic [2:0]           pat_r, pat_nxt;
  logic [2:0]           pos_r, pos_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;

  logic [TIME_BITS-1:0] now_cut;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] dur_ms;
  logic [2:0]           cnt;
  logic [3:0]           pos_inc;
  logic                 status;
  logic                 wrote;

  assign now_cut = item.now_ms[TIME_BITS-1:0];
  assign elapsed = now_cut - start_r;
  assign dur_ms  = TIME_BITS'(step_ms(cfg, pat_r, pos_r));
  assign cnt     = pat_steps(pat_r);
  assign pos_inc = {1'b0, pos_r} + 4'd1;

  // Next pattern state for this item
  always_comb begin
    active_nxt = active_r;
    pat_nxt    = pat_r;
    pos_nxt    = pos_r;
    start_nxt  = start_r;
    status     = 1'b0;
    wrote      = 1'b0;
    unique case (item.kind)
      KIND_PLAY: begin
        if (item.action[3]) begin
          status = 1'b1;
        end else if (item.action[2:0] == PAT_SILENT) begin
          active_nxt = 1'b0;
          pat_nxt    = PAT_SILENT;
          pos_nxt    = 3'd0;
          wrote      = 1'b1;
        end else begin
          active_nxt = 1'b1;
          pat_nxt    = item.action[2:0];
          pos_nxt    = 3'd0;
          start_nxt  = now_cut;
          wrote      = 1'b1;
        end
      end
      KIND_STOP: begin
        active_nxt = 1'b0;
        pat_nxt    = PAT_SILENT;
        pos_nxt    = 3'd0;
        wrote      = 1'b1;
      end
      KIND_TICK: begin
        if (active_r) begin
          if (cnt == 3'd0 || pos_r >= cnt) begin
            // Position out of the pattern: drop to silence
            active_nxt = 1'b0;
            pat_nxt    = PAT_SILENT;
            pos_nxt    = 3'd0;
            wrote      = 1'b1;
          end else if (elapsed >= dur_ms) begin
            wrote = 1'b1;
            if (pos_inc >= {1'b0, cnt}) begin
              if (pat_r == PAT_WARNING || pat_r == PAT_ALARM) begin
                pos_nxt   = 3'd0;
                start_nxt = now_cut;
              end else begin
                active_nxt = 1'b0;
                pat_nxt    = PAT_SILENT;
                pos_nxt    = 3'd0;
              end
            end else begin
              pos_nxt   = pos_inc[2:0];
              start_nxt = now_cut;
            end
          end
        end
      end
      default: begin
        // Unused kind: hold everything
      end
    endcase
  end

  // Assemble the result from the updated state
  always_comb begin
    result.status     = status;
    result.tone_write = wrote;
    result.tone_freq  = active_nxt ? step_freq(cfg, pat_nxt, pos_nxt) : 16'd0;
    result.playing    = active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      pat_r    <= PAT_SILENT;
      pos_r    <= 3'd0;
      start_r  <= '0;
    end else if (item_valid) begin
      active_r <= active_nxt;
      pat_r    <= pat_nxt;
      pos_r    <= pos_nxt;
      start_r  <= start_nxt;
    end
  end

endmodule

[rtl/core/tone_pattern_sequencer_core.sv]
// ----------------------------------------------------------------------------
// Tone pattern sequencer core
// Plays fixed buzzer patterns on play, stop and tick items.
//
// Channel   Ports                          Direction
// input     in_valid, in_ready, in_item    into the core
// result    out_valid, out_ready, out_item out of the core
// config    cfg_we, cfg_index, cfg_wdata   into the core, write only
//
// One item per cycle sustained while out_ready holds high; out_valid rises after
// its item is accepted and passes the input register, then the result register.
// The state update is one pass of lookup, subtract and compare per advancing item.
// Reset is synchronous, active low, and clears state and config registers.
// A stalled result holds in the result register while one more item waits
// in the input register.
// ----------------------------------------------------------------------------
module tone_pattern_sequencer_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tps_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tps_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tps_pkg::*;

  cfg_t      cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;
  out_item_t result;
  logic      s1_adv;
  logic      in_acc;

  tps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tps_engine #(
    .TIME_BITS (TIME_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (s1_adv),
    .item       (s1_item_r),
    .result     (result)
  );

  // Advance the input stage when the result register is free
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

[rtl/core/tps_checker.sv]
// ----------------------------------------------------------------------------
// Tone pattern sequencer checker
// Watches the core's ports for result consistency and handshake holding.
// ----------------------------------------------------------------------------
`include "tone_pattern_sequencer_core_assert.svh"

module tps_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tps_pkg::out_item_t out_item
);
  import tps_pkg::*;

  // No result leaves during reset
  `TPS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid after reset")

  // A stalled result holds
  `TPS_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result dropped")

  // A rejected action never touches the tone
  `TPS_ASSERT(a_reject, out_valid && out_item.status |-> !out_item.tone_write, "reject wrote tone")

  // Silence whenever no pattern plays
  `TPS_ASSERT(a_silent, out_valid && !out_item.playing |-> out_item.tone_freq == 16'd0, "tone while idle")

endmodule

bind tone_pattern_sequencer_core tps_checker u_tps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
